// ===== src/ctcgd_pkg.sv =====
// Shared types, constants and the exponent table of the CTC greedy decoder.
// Used by the front, queue and back modules and by the top level.
package ctcgd_pkg;

	localparam int MAX_CLASSES     = 8192;
	localparam int EXP_TABLE_DEPTH = 1024;
	localparam int EXP_INDEX_SHIFT = 2;
	localparam int CLASS_W         = 13;
	localparam int COUNT_W         = 14;
	localparam int ROM_AW          = $clog2(EXP_TABLE_DEPTH);
	localparam int QUEUE_DEPTH     = 2;
	localparam int DIV_STEPS       = 33;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

	typedef enum logic [0:0] {
		CFG_CLASS_COUNT = 1'b0,
		CFG_KEY_COUNT   = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_LOOK,
		FS_MUL,
		FS_ACC
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_DIV,
		BS_OUT
	} back_state_t;

	typedef struct packed {
		logic [CLASS_W-1:0] win;
		logic [31:0]        exp_sum;
	} row_result_t;

	typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] v;
		v = 64'h1_0000_0000;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			rom[k] = 17'((v + 64'd32768) >> 16);
			v = (v * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== src/ctcgd_front.sv =====
// Front part: accepts logits, tracks row maximum and online softmax sum.
// Depends on ctcgd_pkg; pushes finished rows into the row queue.
module ctcgd_front import ctcgd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [COUNT_W-1:0]  class_count,
	input  logic [COUNT_W-1:0]  key_count,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  logit,
	input  logic                line_start,
	input  logic                q_full,
	output logic                q_push,
	output row_result_t         q_data
);

	front_state_t state_q, state_next;

	logic signed [15:0] x_q;
	logic               start_q;
	logic signed [15:0] row_max_q;
	logic [CLASS_W-1:0] row_idx_q;
	logic [31:0]        exp_sum_q;
	logic [CLASS_W-1:0] col_q;
	logic [CLASS_W-1:0] prev_q;

	logic [CLASS_W-1:0] col_eff_q;
	logic [COUNT_W-1:0] n_q;
	logic               first_q;
	logic               gt_q;
	logic               oob_q;
	logic [16:0]        rom_q;
	logic [48:0]        prod_q;

	logic [COUNT_W-1:0] n_c;
	logic [CLASS_W-1:0] col_c;
	logic [16:0]        diff_c;
	logic [15:0]        mag_c;
	logic [16:0]        entry_c;
	logic [33:0]        scaled_c;
	logic [33:0]        wide_c;
	logic [31:0]        sum_next;
	logic [CLASS_W-1:0] idx_next;
	logic [CLASS_W-1:0] prev_eff;
	logic               row_end;
	logic               emit;

	always_comb begin
		state_next = state_q;
		case (state_q)
			FS_IDLE: if (in_valid && in_ready) state_next = FS_LOOK;
			FS_LOOK: state_next = FS_MUL;
			FS_MUL:  state_next = FS_ACC;
			FS_ACC:  state_next = FS_IDLE;
			default: state_next = FS_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == FS_IDLE) && !q_full;
		q_push   = (state_q == FS_ACC) && row_end && emit;
	end

	always_comb begin
		if (class_count == '0) begin
			n_c = COUNT_W'(1);
		end else if (class_count > COUNT_W'(MAX_CLASSES)) begin
			n_c = COUNT_W'(MAX_CLASSES);
		end else begin
			n_c = class_count;
		end
		col_c = start_q ? '0 : col_q;
		if ({1'b0, col_c} >= n_c) col_c = '0;
		diff_c = (x_q > row_max_q) ? 17'({x_q[15], x_q} - {row_max_q[15], row_max_q})
		                           : 17'({row_max_q[15], row_max_q} - {x_q[15], x_q});
		mag_c = diff_c[15:0];
	end

	always_comb begin
		entry_c  = oob_q ? '0 : rom_q;
		scaled_c = 34'((50'(prod_q) + 50'd32768) >> 16) + 34'(ONE_Q16);
		wide_c   = 34'(exp_sum_q) + 34'(entry_c);
		if (first_q) begin
			sum_next = ONE_Q16;
		end else if (gt_q) begin
			sum_next = (scaled_c[33:32] != '0) ? 32'hFFFF_FFFF : scaled_c[31:0];
		end else begin
			sum_next = wide_c[32] ? 32'hFFFF_FFFF : wide_c[31:0];
		end
		if (first_q) begin
			idx_next = '0;
		end else if (gt_q) begin
			idx_next = col_eff_q;
		end else begin
			idx_next = row_idx_q;
		end
		prev_eff = start_q ? '0 : prev_q;
		row_end  = (COUNT_W'(col_eff_q) + COUNT_W'(1)) >= n_q;
		emit     = (idx_next != '0) && ({1'b0, idx_next} < key_count) && (idx_next != prev_eff);
		q_data.win     = idx_next;
		q_data.exp_sum = sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FS_IDLE;
			row_max_q <= '0;
			row_idx_q <= '0;
			exp_sum_q <= '0;
			col_q     <= '0;
			prev_q    <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == FS_ACC) begin
				exp_sum_q <= sum_next;
				row_idx_q <= idx_next;
				if (first_q || gt_q) row_max_q <= x_q;
				col_q  <= row_end ? '0 : col_eff_q + CLASS_W'(1);
				prev_q <= row_end ? idx_next : prev_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && in_valid && in_ready) begin
			x_q     <= logit;
			start_q <= line_start;
		end
		if (state_q == FS_LOOK) begin
			n_q       <= n_c;
			col_eff_q <= col_c;
			first_q   <= (col_c == '0);
			gt_q      <= (x_q > row_max_q);
			oob_q     <= ((mag_c >> EXP_INDEX_SHIFT) >= 16'(EXP_TABLE_DEPTH));
			rom_q     <= EXP_ROM[ROM_AW'(mag_c >> EXP_INDEX_SHIFT)];
		end
		if (state_q == FS_MUL) begin
			prod_q <= exp_sum_q * entry_c;
		end
	end

endmodule

// ===== src/ctcgd_queue.sv =====
// Short queue of finished rows between the front and back parts.
// Depends on ctcgd_pkg for the row result type and the depth.
module ctcgd_queue import ctcgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  row_result_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output row_result_t pop_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	row_result_t       mem [QUEUE_DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [AW:0]       count_q;

	always_comb begin
		full      = (count_q == (AW+1)'(QUEUE_DEPTH));
		not_empty = (count_q != '0);
		pop_data  = mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + AW'(1);
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

endmodule

// ===== src/ctcgd_back.sv =====
// Back part: divides out the confidence of each row and holds the result.
// Depends on ctcgd_pkg; takes rows from the row queue.
module ctcgd_back import ctcgd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  row_result_t        q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CLASS_W-1:0] key_index,
	output logic [15:0]        confidence
);

	back_state_t state_q, state_next;

	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [32:0] num_q;
	logic [5:0]  step_q;
	logic [CLASS_W-1:0] win_q;

	logic [32:0] rem_sh;
	logic        take;
	logic        last_step;

	always_comb begin
		rem_sh    = {rem_q, num_q[32]};
		take      = rem_sh >= {1'b0, den_q};
		last_step = (step_q == 6'(DIV_STEPS-1));
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			BS_IDLE: if (q_not_empty) state_next = BS_DIV;
			BS_DIV:  if (last_step || den_q == '0) state_next = BS_OUT;
			BS_OUT:  if (out_ready) state_next = BS_IDLE;
			default: state_next = BS_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == BS_IDLE) && q_not_empty;
		out_valid = (state_q == BS_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == BS_IDLE) step_q <= '0;
			else if (state_q == BS_DIV) step_q <= step_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: begin
				den_q <= q_data.exp_sum;
				win_q <= q_data.win;
				rem_q <= '0;
				num_q <= 33'h1_0000_0000 + 33'(q_data.exp_sum >> 1);
			end
			BS_DIV: begin
				if (den_q == '0) begin
					confidence <= 16'hFFFF;
					key_index  <= win_q - CLASS_W'(1);
				end else begin
					rem_q <= take ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
					num_q <= {num_q[31:0], take};
					if (last_step) begin
						confidence <= ({num_q[31:15]} != '0) ? 16'hFFFF : {num_q[14:0], take};
						key_index  <= win_q - CLASS_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/ctc_greedy_softmax_decoder_top.sv =====
// Top level of the CTC greedy decoder with softmax confidence.
// Depends on ctcgd_pkg, ctcgd_front, ctcgd_queue and ctcgd_back.
//
// Logits stream in on the in_valid/in_ready channel, class_count per row, with
// line_start marking the first logit of a new text line. Each logit passes
// through the front sequencer's capture, table read, rescale multiply and
// accumulate steps, and in_ready stays low until the front is done with it.
// At the end of a row that yields a new character, the row goes into a
// two-entry queue. The back part runs a restoring divider, one quotient bit per
// cycle, and then holds key_index and confidence on out_valid until the
// transfer completes. With the back part free, the row result passes from the
// front's accumulate step through the queue and the divider before out_valid
// rises. While the receiver stalls, the front keeps taking logits until the
// queue is full. Configuration writes on cfg_valid/cfg_ready are always taken
// and must be made while the block is idle. Reset clears all row state, the
// repeat memory and the queue, and sets both counts to 5531.
module ctc_greedy_softmax_decoder_top import ctcgd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [COUNT_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] logit,
	input  logic               line_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CLASS_W-1:0] key_index,
	output logic [15:0]        confidence
);

	logic [COUNT_W-1:0] class_count_q;
	logic [COUNT_W-1:0] key_count_q;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_not_empty;
	row_result_t        q_in;
	row_result_t        q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= COUNT_W'(5531);
			key_count_q   <= COUNT_W'(5531);
		end else if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
			case (cfg_index_t'(cfg_index[0]))
				CFG_CLASS_COUNT: class_count_q <= cfg_data;
				CFG_KEY_COUNT:   key_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	ctcgd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.class_count(class_count_q), .key_count(key_count_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.logit(logit), .line_start(line_start),
		.q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	ctcgd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .pop_data(q_out)
	);

	ctcgd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_not_empty(q_not_empty), .q_data(q_out), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.key_index(key_index), .confidence(confidence)
	);

endmodule

// ===== src/ctcgd_checker.sv =====
// Port-level checks of the CTC greedy decoder, bound to the top level.
// Depends on ctcgd_pkg and ctc_greedy_softmax_decoder_top.
module ctcgd_checker import ctcgd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CLASS_W-1:0] key_index,
	input logic [15:0]        confidence
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_index) && $stable(confidence))
		else $error("result changed while stalled");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in consecutive cycles");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_index != '1)
		else $error("blank class emitted");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind ctc_greedy_softmax_decoder_top ctcgd_checker u_checker (
	.clk(clk), .arst_n(arst_n), .cfg_ready(cfg_ready),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.key_index(key_index), .confidence(confidence)
);

// ===== dv/ctc_greedy_softmax_decoder_top_test.sv =====
// Self-checking testbench for the CTC greedy softmax decoder top level.
// Depends on ctcgd_pkg and ctc_greedy_softmax_decoder_top; drives rows of logits and
// compares every emitted character against a decoder prediction or pinned value.
`timescale 1ns / 100ps

module ctc_greedy_softmax_decoder_top_test;
	import ctcgd_pkg::*;

	localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

	typedef struct {
		logic [CLASS_W-1:0] key;
		logic [15:0]        conf;
	} char_t;

	typedef struct {
		logic signed [15:0] logit;
		logic               line_start;
		logic               has_char;
		logic               pinned;
		logic [CLASS_W-1:0] key;
		logic [15:0]        conf;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] logit = '0;
	logic               line_start = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CLASS_W-1:0] key_index;
	logic [15:0]        confidence;

	ctc_greedy_softmax_decoder_top dut (.*);

	always #5 clk = ~clk;

	// Decoder prediction state.
	logic [31:0] exp_lut [EXP_TABLE_DEPTH];
	int unsigned n_classes, n_keys;
	logic signed [15:0] best_logit;
	int unsigned best_col, col_pos, last_win;
	logic [31:0] denom;

	char_t pending_chars[$];
	int    errors = 0;
	bit    quiet = 1'b0;
	bit    hold_out = 1'b0;

	function automatic logic [31:0] exp_of(int unsigned d);
		int unsigned k;
		k = d >> EXP_INDEX_SHIFT;
		return (k >= EXP_TABLE_DEPTH) ? 32'd0 : exp_lut[k];
	endfunction

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Advances the prediction by one logit; returns 1 with the character when a row emits.
	function automatic bit decode_logit(logic signed [15:0] x, logic ls, output char_t c);
		int unsigned n, w;
		logic [63:0] scaled, q;
		n = (n_classes == 0) ? 1 : (n_classes > MAX_CLASSES ? MAX_CLASSES : n_classes);
		if (ls) begin
			last_win = 0;
			col_pos = 0;
		end
		if (col_pos >= n) col_pos = 0;
		if (col_pos == 0) begin
			best_logit = x;
			best_col = 0;
			denom = ONE_Q16;
		end else if (x > best_logit) begin
			scaled = (64'(denom) * 64'(exp_of(int'(x) - int'(best_logit))) + 64'd32768) >> 16;
			denom = add_sat(scaled[31:0], ONE_Q16);
			best_logit = x;
			best_col = col_pos;
		end else begin
			denom = add_sat(denom, exp_of(int'(best_logit) - int'(x)));
		end
		if (col_pos + 1 < n) begin
			col_pos++;
			return 0;
		end
		col_pos = 0;
		w = best_col;
		if (w == 0 || w >= n_keys || w == last_win) begin
			last_win = w;
			return 0;
		end
		last_win = w;
		if (denom == 0) q = 65535;
		else q = (64'h1_0000_0000 + 64'(denom >> 1)) / 64'(denom);
		if (q > 65535) q = 65535;
		c.key = CLASS_W'(w - 1);
		c.conf = q[15:0];
		return 1;
	endfunction

	function automatic void expect_char(char_t c);
		pending_chars = {pending_chars, c};
	endfunction

	task automatic idle_burst(input int pct);
		if (!quiet && $urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= 2'(idx);
		cfg_data <= COUNT_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CLASS_COUNT) n_classes = val;
		else n_keys = val;
		@(posedge clk);
	endtask

	task automatic send_checked(input logic signed [15:0] x, input logic ls, input logic pinned,
	                            input logic has_char, input logic [CLASS_W-1:0] key,
	                            input logic [15:0] conf);
		char_t c;
		bit    hit;
		in_valid <= 1'b1;
		logit <= x;
		line_start <= ls;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hit = decode_logit(x, ls, c);
		if (pinned) begin
			if (has_char) begin
				c.key = key;
				c.conf = conf;
				expect_char(c);
			end
		end else if (hit) expect_char(c);
	endtask

	task automatic send_logit(input logic signed [15:0] x, input logic ls);
		send_checked(x, ls, 1'b0, 1'b0, '0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Receiver side.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected transfer key_index=%0d", key_index);
					errors++;
				end else begin
					char_t c;
					c = pending_chars.pop_front();
					if (key_index !== c.key) begin
						$error("key_index expected %0d actual %0d", c.key, key_index);
						errors++;
					end
					if (confidence !== c.conf) begin
						$error("confidence expected %0d actual %0d", c.conf, confidence);
						errors++;
					end
				end
			end
			if (hold_out) out_ready <= 1'b0;
			else if (!quiet && $urandom_range(99) < 10) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(16, 1)) @(posedge clk);
				out_ready <= 1'b1;
			end else out_ready <= 1'b1;
		end
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Directed rows: class_count 4, key_count 4.
	row_t directed [] = '{
		'{16'sh0000, 1, 0, 0, 0, 0}, '{16'sh0100, 0, 0, 0, 0, 0},
		'{16'sh0000, 0, 0, 0, 0, 0}, '{16'sh0000, 0, 0, 0, 0, 0},
		'{16'sh7FFF, 0, 0, 0, 0, 0}, '{16'sh7FFF, 0, 0, 0, 0, 0},
		'{-16'sd32768, 0, 0, 0, 0, 0}, '{16'sh0000, 0, 0, 0, 0, 0},
		'{-16'sd32768, 0, 0, 0, 0, 0}, '{-16'sd32768, 0, 0, 0, 0, 0},
		'{-16'sd32768, 0, 0, 0, 0, 0}, '{16'sh7FFF, 0, 1, 1, 13'd2, 16'd65535},
		'{16'sh0000, 1, 0, 0, 0, 0}, '{16'sh0000, 0, 0, 0, 0, 0},
		'{16'sh0000, 0, 0, 0, 0, 0}, '{16'sh0000, 0, 0, 0, 0, 0},
		'{16'sh0000, 0, 0, 0, 0, 0}, '{16'sh0000, 1, 0, 0, 0, 0},
		'{16'sh0400, 0, 0, 0, 0, 0}, '{16'sh0400, 0, 0, 0, 0, 0},
		'{16'sh0000, 0, 0, 0, 0, 0}
	};

	task automatic run_random(input int count);
		int unsigned r;
		logic signed [15:0] x;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 70) x = 16'($signed($urandom_range(1024)) - 512);
			else x = 16'($urandom);
			idle_burst(8);
			send_logit(x, $urandom_range(99) < 3);
		end
	endtask

	initial begin
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) exp_lut[k] = 32'(EXP_ROM[k]);
		n_classes = 5531;
		n_keys = 5531;
		col_pos = 0;
		last_win = 0;
		best_logit = 0;
		best_col = 0;
		denom = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_CLASS_COUNT, 4);
		write_reg(CFG_KEY_COUNT, 4);
		foreach (directed[i]) begin
			send_checked(directed[i].logit, directed[i].line_start, directed[i].pinned,
			             directed[i].has_char, directed[i].key, directed[i].conf);
		end
		drain();

		// Zero counts, a wide row and the extremes of the register range.
		write_reg(CFG_CLASS_COUNT, 0);
		write_reg(CFG_KEY_COUNT, 0);
		run_random(10);
		drain();
		write_reg(CFG_CLASS_COUNT, 3);
		write_reg(CFG_KEY_COUNT, 8192);
		send_logit(16'sh0000, 1);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INDEX_UNUSED;
		cfg_data <= '1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		write_reg(CFG_CLASS_COUNT, 16383);
		write_reg(CFG_KEY_COUNT, 16383);
		run_random(100);
		drain();

		write_reg(CFG_CLASS_COUNT, 5);
		write_reg(CFG_KEY_COUNT, 4);
		run_random(400);
		// Long receiver hold while the sender keeps offering.
		hold_out = 1'b1;
		fork
			run_random(60);
			begin
				repeat (400) @(posedge clk);
				hold_out = 1'b0;
			end
		join
		drain();
		write_reg(CFG_CLASS_COUNT, 2);
		write_reg(CFG_KEY_COUNT, 2);
		run_random(300);
		drain();
		write_reg(CFG_CLASS_COUNT, 8);
		write_reg(CFG_KEY_COUNT, 7);
		run_random(300);
		quiet = 1'b1;
		run_random(200);
		drain();

		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ctcgd_pkg.sv
src/ctcgd_front.sv
src/ctcgd_queue.sv
src/ctcgd_back.sv
src/ctc_greedy_softmax_decoder_top.sv
src/ctcgd_checker.sv
dv/ctc_greedy_softmax_decoder_top_test.sv
